[hdl/rra_pkg.sv]
// Package: constants, widths and codes of the ring readback allocator.
`timescale 1ns / 1ps

package rra_pkg;

  localparam int SIZE_W        = 27;
  localparam int OFFSET_W      = 26;
  localparam int FENCE_W       = 64;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int SLOT_OUT_W    = 4;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int MAX_OUT        = 16;
  localparam int NCNT_W         = $clog2(MAX_OUT + 1);

  localparam int ALIGN_BYTES   = 512;
  localparam int RING_MIN_LOG2 = 10;
  localparam logic [SIZE_W-1:0] RING_MIN   = SIZE_W'(1 << RING_MIN_LOG2);
  localparam logic [SIZE_W-1:0] RING_MAX   = SIZE_W'(64 * 1024 * 1024);
  localparam logic [SIZE_W-1:0] RING_RESET = RING_MAX;

  localparam int MOD_STEPS = SIZE_W - RING_MIN_LOG2;
  localparam int MOD_W     = SIZE_W + MOD_STEPS - 1;
  localparam int MODK_W    = $clog2(MOD_STEPS);

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAG    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RETIRE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RING_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE       = 2'd3;

endpackage

[hdl/ring_readback_allocator_unit.sv]
// Top level: ring allocator with slot queue, fence tagging and in-order retirement.
//
// channel   direction  handshake            fields
// command   in         start & !busy        cmd, byte_size, fence_value
// result    out        done (one cycle)     status, offset, aligned_size, slot, last
// config    in         cfg_wr               cfg_data (ring_size)
//
// Allocate: after acceptance, busy in the S_ALLOC evaluate state, which registers the result.
// Tag: one slot entry per cycle over the fence store, sweeping all SLOT_COUNT slots.
// Retire: per checked slot, a registered read of the slot store (S_RREAD), then compare (S_RCHECK),
//   then a shift-subtract remainder (S_MOD) for the new ring start when any slot frees.
// Reset: rst synchronous, clears control state; ring_size returns to 64 MiB.
// The receiver cannot stall: each result shows for exactly one cycle with done high.
`timescale 1ns / 1ps

module ring_readback_allocator_unit #(
  parameter int SLOT_COUNT = rra_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr,
  input  logic [rra_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [rra_pkg::CMD_W-1:0]     cmd,
  input  logic [rra_pkg::SIZE_W-1:0]    byte_size,
  input  logic [rra_pkg::FENCE_W-1:0]   fence_value,
  output logic                          done,
  output logic [rra_pkg::STATUS_W-1:0]  status,
  output logic [rra_pkg::OFFSET_W-1:0]  offset,
  output logic [rra_pkg::SIZE_W-1:0]    aligned_size,
  output logic [rra_pkg::SLOT_OUT_W-1:0] slot,
  output logic                          last
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int UW = $clog2(SLOT_COUNT + 1);
  localparam int SW = rra_pkg::SIZE_W;
  localparam int OW = rra_pkg::OFFSET_W;
  localparam int FW = rra_pkg::FENCE_W;
  localparam logic [SW:0] ALIGN_MASK = (SW + 1)'(rra_pkg::ALIGN_BYTES - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ALLOC  = 3'd1;
  localparam logic [2:0] S_TAG    = 3'd2;
  localparam logic [2:0] S_RREAD  = 3'd3;
  localparam logic [2:0] S_RCHECK = 3'd4;
  localparam logic [2:0] S_MOD    = 3'd5;

  logic [2:0]     state;
  logic [SW-1:0]  ring_size;
  logic [SW-1:0]  used_start;
  logic [SW-1:0]  used_end;
  logic [IW-1:0]  head_slot;
  logic [UW-1:0]  slots_in_use;
  logic [SLOT_COUNT-1:0] slot_untagged;

  logic [SW-1:0]  req;
  logic [FW-1:0]  fence;
  logic [IW-1:0]  tag_idx;
  logic [rra_pkg::NCNT_W-1:0] n_cnt;
  logic           have_pend;
  logic [OW-1:0]  pend_off;
  logic [SW-1:0]  pend_size;
  logic [IW-1:0]  pend_slot;
  logic [SW-1:0]  mod_val;
  logic [rra_pkg::MOD_W-1:0] mod_div;
  logic [rra_pkg::MODK_W-1:0] mod_k;

  logic [OW-1:0]  slot_offset [SLOT_COUNT];
  logic [SW-1:0]  slot_size   [SLOT_COUNT];
  logic [FW-1:0]  slot_fence  [SLOT_COUNT];
  logic [OW-1:0]  rd_off;
  logic [SW-1:0]  rd_size;
  logic [FW-1:0]  rd_fence;

  logic [SW-1:0]  ring_eff;
  logic [SW:0]    aligned_full;
  logic [SW-1:0]  aligned_sat;
  logic [SW+1:0]  end_sum;
  logic           fit_tail;
  logic           fit_wrap;
  logic           fit_mid;
  logic           queue_full;
  logic [IW:0]    tail_sum;
  logic [IW-1:0]  tail_idx;
  logic [IW-1:0]  head_inc;
  logic           alloc_ok;
  logic           alloc_wrap;
  logic [OW-1:0]  alloc_pos;
  logic           retire_ok;
  logic           tag_wr;
  logic [IW+3:0]  tail_wide;
  logic [IW+3:0]  pend_wide;
  logic [rra_pkg::MOD_W-1:0] mod_val_wide;
  logic           accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  always_comb begin
    if (ring_size < rra_pkg::RING_MIN) begin
      ring_eff = rra_pkg::RING_MIN;
    end else if (ring_size > rra_pkg::RING_MAX) begin
      ring_eff = rra_pkg::RING_MAX;
    end else begin
      ring_eff = ring_size;
    end
  end

  assign aligned_full = ({1'b0, req} + ALIGN_MASK) & ~ALIGN_MASK;
  assign aligned_sat  = aligned_full[SW] ? {SW{1'b1}} : aligned_full[SW-1:0];
  assign end_sum      = {2'b00, used_end} + {1'b0, aligned_full};
  assign fit_tail     = end_sum < {2'b00, ring_eff};
  assign fit_wrap     = aligned_full < {1'b0, used_start};
  assign fit_mid      = end_sum < {2'b00, used_start};
  assign queue_full   = (slots_in_use >= UW'(SLOT_COUNT));

  always_comb begin
    alloc_wrap = 1'b0;
    if (queue_full) begin
      alloc_ok = 1'b0;
    end else if (used_start <= used_end) begin
      alloc_ok   = fit_tail || fit_wrap;
      alloc_wrap = !fit_tail;
    end else begin
      alloc_ok = fit_mid;
    end
    alloc_pos = alloc_wrap ? '0 : used_end[OW-1:0];
  end

  assign tail_sum = {1'b0, head_slot} + (IW + 1)'(slots_in_use);
  assign tail_idx = (tail_sum >= (IW + 1)'(SLOT_COUNT)) ?
                    IW'(tail_sum - (IW + 1)'(SLOT_COUNT)) : tail_sum[IW-1:0];
  assign head_inc = (head_slot == IW'(SLOT_COUNT - 1)) ? '0 : head_slot + 1'b1;

  assign retire_ok = (n_cnt < rra_pkg::NCNT_W'(rra_pkg::MAX_OUT)) &&
                     (slots_in_use != '0) && !slot_untagged[head_slot] &&
                     !(fence < rd_fence);

  assign tag_wr       = (state == S_TAG) && slot_untagged[tag_idx];
  assign tail_wide    = (IW + 4)'(tail_idx);
  assign pend_wide    = (IW + 4)'(pend_slot);
  assign mod_val_wide = rra_pkg::MOD_W'(mod_val);

  always_ff @(posedge clk) begin
    if (state == S_ALLOC && alloc_ok) begin
      slot_offset[tail_idx] <= alloc_pos;
      slot_size[tail_idx]   <= aligned_full[SW-1:0];
    end
    rd_off  <= slot_offset[head_slot];
    rd_size <= slot_size[head_slot];
  end

  always_ff @(posedge clk) begin
    if (tag_wr) begin
      slot_fence[tag_idx] <= fence;
    end
    rd_fence <= slot_fence[head_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= rra_pkg::RING_RESET;
    end else if (cfg_wr) begin
      ring_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used_start    <= '0;
      used_end      <= '0;
      head_slot     <= '0;
      slots_in_use  <= '0;
      slot_untagged <= '0;
      done          <= 1'b0;
      have_pend     <= 1'b0;
      n_cnt         <= '0;
      tag_idx       <= '0;
      mod_k         <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            req       <= byte_size;
            fence     <= fence_value;
            tag_idx   <= '0;
            n_cnt     <= '0;
            have_pend <= 1'b0;
            case (cmd)
              rra_pkg::CMD_ALLOC:  state <= S_ALLOC;
              rra_pkg::CMD_TAG:    state <= S_TAG;
              rra_pkg::CMD_RETIRE: state <= S_RREAD;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_ALLOC: begin
          done         <= 1'b1;
          last         <= 1'b1;
          aligned_size <= aligned_sat;
          if (queue_full) begin
            status <= rra_pkg::ST_QUEUE_FULL;
            offset <= '0;
            slot   <= '0;
          end else if (!alloc_ok) begin
            status <= rra_pkg::ST_RING_FULL;
            offset <= '0;
            slot   <= '0;
          end else begin
            status                  <= rra_pkg::ST_OK;
            offset                  <= alloc_pos;
            slot                    <= tail_wide[3:0];
            used_end                <= alloc_wrap ? aligned_full[SW-1:0] : end_sum[SW-1:0];
            slot_untagged[tail_idx] <= 1'b1;
            slots_in_use            <= slots_in_use + 1'b1;
          end
          state <= S_IDLE;
        end
        S_TAG: begin
          slot_untagged[tag_idx] <= 1'b0;
          if (tag_idx == IW'(SLOT_COUNT - 1)) begin
            done         <= 1'b1;
            status       <= rra_pkg::ST_OK;
            offset       <= '0;
            aligned_size <= '0;
            slot         <= '0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            tag_idx <= tag_idx + 1'b1;
          end
        end
        S_RREAD: begin
          state <= S_RCHECK;
        end
        S_RCHECK: begin
          if (retire_ok) begin
            if (have_pend) begin
              done         <= 1'b1;
              status       <= rra_pkg::ST_OK;
              offset       <= pend_off;
              aligned_size <= pend_size;
              slot         <= pend_wide[3:0];
              last         <= 1'b0;
            end
            have_pend    <= 1'b1;
            pend_off     <= rd_off;
            pend_size    <= rd_size;
            pend_slot    <= head_slot;
            n_cnt        <= n_cnt + 1'b1;
            head_slot    <= head_inc;
            slots_in_use <= slots_in_use - 1'b1;
            state        <= S_RREAD;
          end else if (have_pend) begin
            done         <= 1'b1;
            status       <= rra_pkg::ST_OK;
            offset       <= pend_off;
            aligned_size <= pend_size;
            slot         <= pend_wide[3:0];
            last         <= 1'b1;
            mod_val      <= SW'(pend_off) + pend_size;
            mod_div      <= rra_pkg::MOD_W'(ring_eff) << (rra_pkg::MOD_STEPS - 1);
            mod_k        <= rra_pkg::MODK_W'(rra_pkg::MOD_STEPS - 1);
            state        <= S_MOD;
          end else begin
            done         <= 1'b1;
            status       <= rra_pkg::ST_NONE;
            offset       <= '0;
            aligned_size <= '0;
            slot         <= '0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_MOD: begin
          if (mod_val_wide >= mod_div) begin
            mod_val <= mod_val - mod_div[SW-1:0];
          end
          mod_div <= mod_div >> 1;
          if (mod_k == '0) begin
            used_start <= (mod_val_wide >= mod_div) ? mod_val - mod_div[SW-1:0] : mod_val;
            state      <= S_IDLE;
          end else begin
            mod_k <= mod_k - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    slots_in_use <= UW'(SLOT_COUNT))
    else $error("slot queue count above capacity");

  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results in consecutive cycles");

  a_start_bound: assert property (@(posedge clk) disable iff (rst)
    used_start < rra_pkg::RING_MAX)
    else $error("ring start beyond largest ring");

  a_noop_cmd: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == rra_pkg::CMD_NONE |=> !busy && !done)
    else $error("unknown command took effect");

  a_tag_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_TAG && tag_idx == IW'(SLOT_COUNT - 1) |=> slot_untagged == '0)
    else $error("untagged slot left after tag sweep");

  a_retire_order: assert property (@(posedge clk) disable iff (rst)
    state == S_RCHECK && retire_ok |=> slots_in_use == $past(slots_in_use) - 1'b1)
    else $error("retire did not release one slot");

endmodule
